/* hdl/thp_pkg.sv */
// Shared types and constants for the TIFF horizontal predictor.
// Used by every module of the block; depends on nothing.
package thp_pkg;

  localparam int unsigned MaxChannels   = 8;
  localparam int unsigned ChanW         = 3;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned ColsW         = 16;
  localparam int unsigned SppW          = 4;
  localparam int unsigned BpsW          = 5;
  localparam int unsigned TotalW        = 20;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned MaxResults    = 3;
  localparam int unsigned ResCntW       = 2;
  localparam int unsigned OutFifoDepth  = 8;
  localparam int unsigned OutFifoPtrW   = 3;
  localparam int unsigned OutFifoCntW   = 4;

  // At most eight samples can complete on one byte (one-bit samples).
  localparam int unsigned NumLanes      = 8;

  // Sample j of a byte (j >= 1) exists only when j times the sample width is
  // at most 7, so the later lanes never carry more than these bits.
  localparam logic [SampleW-1:0] LaneMask [NumLanes] = '{
    16'hFFFF, 16'h007F, 16'h0007, 16'h0003,
    16'h0001, 16'h0001, 16'h0001, 16'h0001
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgDecodeMode      = 2'd0,
    CfgColumns         = 2'd1,
    CfgSamplesPerPixel = 2'd2,
    CfgBitsPerSample   = 2'd3
  } cfg_idx_e;

  localparam logic CmdData = 1'b0;
  localparam logic CmdPad  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_end;
    logic       last;
  } out_req_t;

  // Effective (saturated) configuration as seen by the datapath.
  typedef struct packed {
    logic              decode_mode;
    logic [SppW-1:0]   spp;
    logic [BpsW-1:0]   bps;
    logic [TotalW-1:0] total;
  } cfg_t;

endpackage

/* hdl/thp_cfg.sv */
// Configuration registers of the TIFF horizontal predictor, with saturation
// and the samples-per-row product. Depends on thp_pkg.
module thp_cfg import thp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o,
  output logic                row_clear_o
);

  logic              decode_q, decode_d;
  logic [ColsW-1:0]  cols_q, cols_d;
  logic [SppW-1:0]   spp_q, spp_d;
  logic [BpsW-1:0]   bps_q, bps_d;
  logic [TotalW-1:0] total_q, total_d;

  always_comb begin
    decode_d = decode_q;
    cols_d   = cols_q;
    spp_d    = spp_q;
    bps_d    = bps_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgDecodeMode: begin
          decode_d = cfg_data_i[0];
        end
        CfgColumns: begin
          cols_d = (cfg_data_i == '0) ? ColsW'(1) : cfg_data_i;
        end
        CfgSamplesPerPixel: begin
          if (cfg_data_i[SppW-1:0] == '0) begin
            spp_d = SppW'(1);
          end else if (cfg_data_i[SppW-1:0] > SppW'(MaxChannels)) begin
            spp_d = SppW'(MaxChannels);
          end else begin
            spp_d = cfg_data_i[SppW-1:0];
          end
        end
        CfgBitsPerSample: begin
          if (cfg_data_i[BpsW-1:0] == '0) begin
            bps_d = BpsW'(1);
          end else if (cfg_data_i[BpsW-1:0] > BpsW'(SampleW)) begin
            bps_d = BpsW'(SampleW);
          end else begin
            bps_d = cfg_data_i[BpsW-1:0];
          end
        end
        default: begin
          decode_d = decode_q;
        end
      endcase
    end
    // Fits: 65535 columns times 8 channels is below 2^20.
    total_d = TotalW'(cols_d) * TotalW'(spp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q <= 1'b0;
      cols_q   <= ColsW'(1);
      spp_q    <= SppW'(1);
      bps_q    <= BpsW'(8);
      total_q  <= TotalW'(1);
    end else begin
      decode_q <= decode_d;
      cols_q   <= cols_d;
      spp_q    <= spp_d;
      bps_q    <= bps_d;
      total_q  <= total_d;
    end
  end

  assign cfg_o.decode_mode = decode_q;
  assign cfg_o.spp         = spp_q;
  assign cfg_o.bps         = bps_q;
  assign cfg_o.total       = total_q;

  // Every register write restarts the row.
  assign row_clear_o = cfg_we_i;

endmodule

/* hdl/thp_predict.sv */
// Row state and single-pass sample datapath of the TIFF horizontal predictor:
// unpacks the samples of one byte, predicts, repacks. Depends on thp_pkg.
module thp_predict import thp_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfg_t                            cfg_i,
  input  logic                            row_clear_i,
  input  logic                            item_valid_i,
  input  in_req_t                         item_i,
  output logic [ResCntW-1:0]              res_cnt_o,
  output out_req_t [MaxResults-1:0]       res_o
);

  logic [SampleW-1:0] prev_q [MaxChannels];
  logic [SampleW-1:0] prev_d [MaxChannels];
  logic [15:0]        ibuf_q, ibuf_d;
  logic [3:0]         ibcnt_q, ibcnt_d;
  logic [7:0]         obuf_q, obuf_d;
  logic [2:0]         obcnt_q, obcnt_d;
  logic [ChanW-1:0]   chan_q, chan_d;
  logic [TotalW-1:0]  left_q, left_d;
  logic               fresh_q, fresh_d;

  logic [7:0]         byte_in;
  logic [23:0]        win, wal, vsum, obig;
  logic [4:0]         ccnt, cons, tot, rem;
  logic [16:0]        mask_w;
  logic [SampleW-1:0] mask;
  logic [TotalW-1:0]  left_eff;
  logic [7:0]         off [NumLanes];
  logic [7:0]         sh [NumLanes];
  logic [NumLanes-1:0] en;
  logic [SppW-1:0]    ch [NumLanes+1];
  logic [SampleW-1:0] s [NumLanes];
  logic [SampleW-1:0] pred [NumLanes];
  logic [SampleW-1:0] v [NumLanes];
  logic [SampleW-1:0] w [NumLanes];
  logic [3:0]         k;
  logic [1:0]         nb;
  logic [7:0]         lo_byte;
  logic [ResCntW-1:0] nres;
  logic               skip, act, at_end, flush;

  assign skip     = (item_i.cmd == CmdPad) && fresh_q;
  assign act      = item_valid_i && !skip;
  assign byte_in  = (item_i.cmd == CmdPad) ? 8'h00 : item_i.in_byte;
  assign win      = {ibuf_q, byte_in};
  assign ccnt     = 5'(ibcnt_q) + 5'd8;
  assign wal      = win << (5'd24 - ccnt);
  assign mask_w   = (17'd1 << cfg_i.bps) - 17'd1;
  assign mask     = mask_w[SampleW-1:0];
  assign left_eff = fresh_q ? cfg_i.total : left_q;

  // Lanes: sample j ends (j+1)*bps bits into the left-aligned window.
  always_comb begin
    k    = '0;
    cons = '0;
    for (int j = 0; j < NumLanes; j++) begin
      off[j] = 8'(cfg_i.bps) * 8'(j + 1);
      sh[j]  = 8'd24 - off[j];
      en[j]  = (off[j] <= 8'(ccnt)) && (left_eff > TotalW'(j));
      if (en[j]) begin
        k    = 4'(j + 1);
        cons = off[j][4:0];
      end
    end
  end

  always_comb begin
    ch[0] = SppW'(chan_q);
    for (int j = 0; j < NumLanes; j++) begin
      ch[j+1] = ((ch[j] + SppW'(1)) == cfg_i.spp) ? '0 : ch[j] + SppW'(1);
    end
  end

  // Prediction chain: a sample takes its predecessor from an earlier lane of
  // the same byte when one shares its channel, else from the saved sample.
  always_comb begin
    for (int j = 0; j < NumLanes; j++) begin
      s[j] = en[j] ? (SampleW'(wal >> sh[j]) & mask & LaneMask[j]) : '0;
      pred[j] = prev_q[ch[j][ChanW-1:0]];
      for (int i = 0; i < j; i++) begin
        if ((SppW'(i) + cfg_i.spp) == SppW'(j)) begin
          pred[j] = w[i];
        end
      end
      if (cfg_i.decode_mode) begin
        v[j] = (s[j] + pred[j]) & mask & LaneMask[j];
        w[j] = v[j];
      end else begin
        v[j] = (s[j] - pred[j]) & mask & LaneMask[j];
        w[j] = s[j];
      end
    end
  end

  // Results land in the bit positions that the input samples held.
  always_comb begin
    vsum = '0;
    for (int j = 0; j < NumLanes; j++) begin
      if (en[j]) begin
        vsum = vsum | (24'(v[j]) << sh[j]);
      end
    end
  end

  assign obig  = {obuf_q, 16'h0000} | (vsum >> obcnt_q);
  assign tot   = 5'(obcnt_q) + cons;
  assign nb    = tot[4:3];
  assign rem   = ccnt - cons;

  always_comb begin
    unique case (nb)
      2'd0:    lo_byte = obig[23:16];
      2'd1:    lo_byte = obig[15:8];
      2'd2:    lo_byte = obig[7:0];
      default: lo_byte = 8'h00;
    endcase
  end

  assign at_end = (left_eff == TotalW'(k));
  assign flush  = at_end && (tot[2:0] != 3'd0);
  assign nres   = nb + ResCntW'(flush);

  always_comb begin
    res_o[0].out_byte = (nb != 2'd0) ? obig[23:16] : lo_byte;
    res_o[1].out_byte = (nb == 2'd2) ? obig[15:8] : lo_byte;
    res_o[2].out_byte = lo_byte;
    for (int i = 0; i < MaxResults; i++) begin
      res_o[i].last    = (nres == ResCntW'(i + 1));
      res_o[i].row_end = at_end && (nres == ResCntW'(i + 1));
    end
  end

  assign res_cnt_o = act ? nres : '0;

  always_comb begin
    prev_d  = prev_q;
    ibuf_d  = ibuf_q;
    ibcnt_d = ibcnt_q;
    obuf_d  = obuf_q;
    obcnt_d = obcnt_q;
    chan_d  = chan_q;
    left_d  = left_q;
    fresh_d = fresh_q;
    if (row_clear_i || (act && at_end)) begin
      for (int c = 0; c < MaxChannels; c++) begin
        prev_d[c] = '0;
      end
      ibuf_d  = '0;
      ibcnt_d = '0;
      obuf_d  = '0;
      obcnt_d = '0;
      chan_d  = '0;
      fresh_d = 1'b1;
    end else if (act) begin
      for (int c = 0; c < MaxChannels; c++) begin
        for (int j = 0; j < NumLanes; j++) begin
          if (en[j] && (ch[j] == SppW'(c))) begin
            prev_d[c] = w[j];
          end
        end
      end
      ibcnt_d = rem[3:0];
      ibuf_d  = win[15:0] & ((16'd1 << rem[3:0]) - 16'd1);
      obuf_d  = lo_byte;
      obcnt_d = tot[2:0];
      for (int j = 0; j <= NumLanes; j++) begin
        if (k == 4'(j)) begin
          chan_d = ch[j][ChanW-1:0];
        end
      end
      left_d  = left_eff - TotalW'(k);
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MaxChannels; c++) begin
        prev_q[c] <= '0;
      end
      ibuf_q  <= '0;
      ibcnt_q <= '0;
      obuf_q  <= '0;
      obcnt_q <= '0;
      chan_q  <= '0;
      left_q  <= '0;
      fresh_q <= 1'b1;
    end else begin
      prev_q  <= prev_d;
      ibuf_q  <= ibuf_d;
      ibcnt_q <= ibcnt_d;
      obuf_q  <= obuf_d;
      obcnt_q <= obcnt_d;
      chan_q  <= chan_d;
      left_q  <= left_d;
      fresh_q <= fresh_d;
    end
  end

  // Leftover input bits never make up a whole sample between bytes.
  a_ibcnt_below_bps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ibcnt_q} < cfg_i.bps)
    else $error("input bit count reached a whole sample");

  a_chan_below_spp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, chan_q} < cfg_i.spp)
    else $error("channel index outside the pixel");

  a_row_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && at_end) |-> (res_cnt_o != '0))
    else $error("row ended without a result byte");

endmodule

/* hdl/thp_out_fifo.sv */
// Result queue of the TIFF horizontal predictor: takes up to three result
// bytes per cycle and hands them out one at a time. Depends on thp_pkg.
module thp_out_fifo import thp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ResCntW-1:0]        push_cnt_i,
  input  out_req_t [MaxResults-1:0] push_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output out_req_t                  out_o
);

  out_req_t               mem_q [OutFifoDepth];
  logic [OutFifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OutFifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OutFifoCntW-1:0] cnt_q, cnt_d;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= OutFifoCntW'(OutFifoDepth - MaxResults));

  always_comb begin
    wr_ptr_d = wr_ptr_q + OutFifoPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + OutFifoPtrW'(pop);
    cnt_d    = cnt_q + OutFifoCntW'(push_cnt_i) - OutFifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (ResCntW'(i) < push_cnt_i) begin
        mem_q[wr_ptr_q + OutFifoPtrW'(i)] <= push_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OutFifoCntW'(OutFifoDepth))
    else $error("result queue overflowed");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != '0) |-> room_o)
    else $error("results pushed without room for a full burst");

  a_push_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i <= ResCntW'(MaxResults))
    else $error("more results than one byte can cause");

endmodule

/* hdl/tiff_horizontal_predictor_top.sv */
// Top level of the TIFF horizontal predictor (predictor 2 differencing).
// Instantiates thp_cfg, thp_predict and thp_out_fifo; depends on thp_pkg.
//
//   Channel   Handshake                  Payload                        Direction
//   config    cfg_we_i                   cfg_idx_i, cfg_data_i          in
//   input     in_valid_i / in_ready_o    in_req_i (cmd, in_byte)        in
//   output    out_valid_o / out_ready_i  out_req_o (out_byte, row_end,  out
//                                        last)
//
// One input byte is taken per clock while the result queue has room. A
// request waits in the input register, its samples are unpacked, predicted
// and repacked in a single pass, and its zero to three result bytes enter the
// result queue, from which the first result is offered on out_valid_o. The
// result queue (eight entries) sets the stall point: input is held off while
// the input register is full and the queue has room for fewer than three
// bytes, so a stalled output side backs up into in_ready_o. Reset is
// asynchronous and active low; it restores the default configuration (encode,
// one column, one channel, eight bits) and clears all row state.
//
// Each configuration write restarts the current row: saved samples, bit
// buffers and the channel position are cleared. Writes are meant to happen
// only while no request is in flight. A pad request (cmd high) acts as a
// zero data byte, letting a caller finish a partial row; at the start of a
// row it is consumed with no result.
//
// Within a byte the samples are handled as parallel lanes: with narrow
// samples up to eight complete on one byte, and a lane whose channel repeats
// inside the byte takes its predecessor from the earlier lane rather than
// from the saved per-channel register.
module tiff_horizontal_predictor_top import thp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_req_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_req_t            out_req_o
);

  cfg_t                      cfg;
  logic                      row_clear;
  logic                      inq_valid_q, inq_valid_d;
  in_req_t                   inq_q;
  logic                      room;
  logic                      advance;
  logic                      accept;
  logic [ResCntW-1:0]        res_cnt;
  out_req_t [MaxResults-1:0] res;

  thp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .row_clear_o (row_clear)
  );

  // Input register: it drains into the datapath whenever the result queue
  // can take a full burst, and refills in the same cycle.
  assign advance    = inq_valid_q && room;
  assign in_ready_o = !inq_valid_q || room;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    inq_valid_d = inq_valid_q;
    if (accept) begin
      inq_valid_d = 1'b1;
    end else if (advance) begin
      inq_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inq_q <= in_req_i;
    end
  end

  thp_predict u_predict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .row_clear_i  (row_clear),
    .item_valid_i (advance),
    .item_i       (inq_q),
    .res_cnt_o    (res_cnt),
    .res_o        (res)
  );

  thp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_req_o)
  );

endmodule
